### rtl/pbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbf_pkg
// Shared types and constants for the PCM byte to binary32 sample converter.
// ----------------------------------------------------------------------------
package pbf_pkg;

    localparam int MAX_CHANNELS = 8;
    // channel_index is 3 bits wide, so a frame never exceeds 8 channels
    localparam int CHAN_LIMIT   = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;

    localparam logic [1:0] REG_ENCODING = 2'd0;
    localparam logic [1:0] REG_SIZE     = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    localparam logic ENC_PCM   = 1'b0;
    localparam logic ENC_FLOAT = 1'b1;

    // Work item handed from the byte assembler to the converter.
    typedef struct packed {
        logic        err;
        logic        is_float;
        logic [1:0]  nbytes_m1;
        logic [31:0] raw;
        logic [2:0]  chan;
        logic        last;
    } pbf_item_t;

endpackage : pbf_pkg
`default_nettype wire

### rtl/pbf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbf_front
// Byte assembler: collects sample bytes and tracks channel position.
// ----------------------------------------------------------------------------
module pbf_front
    import pbf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [3:0] cfg_data,
    input  wire logic       in_fire,
    input  wire logic [7:0] data_byte,
    input  wire logic       packet_end,
    output pbf_item_t       item,
    output logic            item_valid
);

    logic       enc_reg;
    logic [1:0] size_reg;
    logic [3:0] chans_reg;
    logic [23:0] acc_reg, acc_next;
    logic [1:0] pos_reg, pos_next;
    logic [2:0] chan_reg, chan_next;

    logic [1:0] nb_m1;
    logic [2:0] nch_m1;
    logic       done, last;
    logic [31:0] raw;

    always_comb
    begin
        nb_m1 = (enc_reg == ENC_FLOAT) ? 2'd3 : size_reg;
        if (chans_reg == 4'd0)
            nch_m1 = 3'd0;
        else if (chans_reg > 4'(CHAN_LIMIT))
            nch_m1 = 3'(CHAN_LIMIT - 1);
        else
            nch_m1 = 3'(chans_reg - 4'd1);
        done = (pos_reg == nb_m1) || (pos_reg > nb_m1);
        last = done && (chan_reg == nch_m1 || chan_reg > nch_m1);
        case (pos_reg)
            2'd0: raw = {24'd0, data_byte};
            2'd1: raw = {16'd0, data_byte, acc_reg[7:0]};
            2'd2: raw = {8'd0, data_byte, acc_reg[15:0]};
            default: raw = {data_byte, acc_reg};
        endcase
        acc_next  = acc_reg;
        pos_next  = pos_reg;
        chan_next = chan_reg;
        item_valid = 1'b0;
        if (in_fire)
        begin
            if (!done)
            begin
                case (pos_reg)
                    2'd0: acc_next[7:0]   = data_byte;
                    2'd1: acc_next[15:8]  = data_byte;
                    default: acc_next[23:16] = data_byte;
                endcase
                pos_next = pos_reg + 2'd1;
            end
            if (packet_end && !last)
            begin
                pos_next  = 2'd0;
                chan_next = 3'd0;
                item_valid = 1'b1;
            end
            else if (done)
            begin
                pos_next  = 2'd0;
                chan_next = last ? 3'd0 : chan_reg + 3'd1;
                item_valid = 1'b1;
            end
        end
        item.err       = packet_end && !last;
        item.is_float  = enc_reg;
        item.nbytes_m1 = nb_m1;
        item.raw       = raw;
        item.chan      = chan_reg;
        item.last      = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg   <= ENC_PCM;
            size_reg  <= 2'd1;
            chans_reg <= 4'd2;
            acc_reg   <= '0;
            pos_reg   <= '0;
            chan_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENCODING: enc_reg   <= cfg_data[0];
                REG_SIZE:     size_reg  <= cfg_data[1:0];
                REG_CHANNELS: chans_reg <= cfg_data;
                default: ;
            endcase
            pos_reg  <= '0;
            chan_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            pos_reg  <= pos_next;
            chan_reg <= chan_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= nb_m1 || $past(cfg_we) || $past(!rst_n))
        else $error("byte position beyond sample size");
    a_chan_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && item_valid && item.last && !cfg_we |=> chan_reg == 3'd0)
        else $error("channel did not wrap after frame end");
    a_err_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && item_valid && item.err && !cfg_we |=> pos_reg == 2'd0)
        else $error("position not restarted after packet error");
`endif

endmodule : pbf_front
`default_nettype wire

### rtl/pbf_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbf_fifo
// Two-entry queue between the byte assembler and the converter.
// ----------------------------------------------------------------------------
module pbf_fifo
    import pbf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire pbf_item_t wr_item,
    output logic           full,
    input  wire logic      rd_en,
    output pbf_item_t      rd_item,
    output logic           not_empty
);

    pbf_item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign rd_item   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full && !rd_en)) else $error("queue overflow");
    a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && !not_empty)) else $error("queue underflow");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("bad queue count");
`endif

endmodule : pbf_fifo
`default_nettype wire

### rtl/pbf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbf_back
// Converter: two-stage integer to binary32 scaling, or binary32 pass-through, with output register.
// ----------------------------------------------------------------------------
module pbf_back
    import pbf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire pbf_item_t   q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             sample_valid,
    output logic [31:0]      sample_value,
    output logic [2:0]       channel_index,
    output logic             frame_end,
    output logic             packet_error
);

    // stage 1: sign, magnitude, exponent bias
    logic        s1_v_reg;
    logic        s1_err_reg, s1_flt_reg, s1_neg_reg, s1_last_reg;
    logic [31:0] s1_mag_reg;
    logic [4:0]  s1_k_reg;
    logic [2:0]  s1_ch_reg;

    logic        neg;
    logic [31:0] mag, sext;
    logic [4:0]  k;
    logic        adv1, adv2;

    logic        o_v_reg;

    assign adv2  = !o_v_reg || !out_stall;
    assign adv1  = !s1_v_reg || adv2;
    assign q_pop = q_valid && adv1;

    always_comb
    begin
        neg  = 1'b0;
        sext = q_item.raw;
        k    = 5'd31;
        case (q_item.nbytes_m1)
            2'd0:
            begin
                neg  = !q_item.raw[7];
                sext = {{24{neg}}, ~q_item.raw[7], q_item.raw[6:0]};
                k    = 5'd7;
            end
            2'd1:
            begin
                neg  = q_item.raw[15];
                sext = {{16{neg}}, q_item.raw[15:0]};
                k    = 5'd15;
            end
            2'd2:
            begin
                neg  = q_item.raw[23];
                sext = {{8{neg}}, q_item.raw[23:0]};
                k    = 5'd23;
            end
            default:
            begin
                neg  = q_item.raw[31];
                sext = q_item.raw;
                k    = 5'd31;
            end
        endcase
        mag = neg ? (~sext + 32'd1) : sext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (adv1)
            s1_v_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_err_reg  <= q_item.err;
            s1_flt_reg  <= q_item.is_float;
            s1_neg_reg  <= neg;
            s1_mag_reg  <= q_item.is_float ? q_item.raw : mag;
            s1_k_reg    <= k;
            s1_ch_reg   <= q_item.chan;
            s1_last_reg <= q_item.last;
        end
    end

    // stage 2: leading one, round to nearest even
    logic [4:0]  p;
    logic [31:0] norm;
    logic [23:0] mant;
    logic [24:0] mant_r;
    logic        rnd;
    logic [7:0]  bexp;
    logic [31:0] fval;

    always_comb
    begin
        p = 5'd0;
        for (int i = 0; i < 32; i++)
            if (s1_mag_reg[i])
                p = 5'(i);
        norm = s1_mag_reg << (5'd31 - p);
        mant = norm[31:8];
        rnd  = norm[7] && (norm[6:0] != 7'd0 || mant[0]);
        mant_r = {1'b0, mant} + {24'd0, rnd};
        bexp = 8'd127 + {3'd0, p} - {3'd0, s1_k_reg} + {7'd0, mant_r[24]};
        if (s1_mag_reg == 32'd0)
            fval = 32'd0;
        else
            fval = {s1_neg_reg, bexp, mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
        if (s1_flt_reg)
            fval = (s1_mag_reg[30:23] == 8'hFF) ? 32'd0 : s1_mag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (adv2)
            o_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_v_reg)
        begin
            sample_valid  <= !s1_err_reg;
            sample_value  <= s1_err_reg ? 32'd0 : fval;
            channel_index <= s1_err_reg ? 3'd0 : s1_ch_reg;
            frame_end     <= s1_err_reg ? 1'b0 : s1_last_reg;
            packet_error  <= s1_err_reg;
        end
    end

    assign out_valid = o_v_reg;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && out_stall |=> o_v_reg && $stable(sample_value))
        else $error("output changed under stall");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg |-> !(sample_valid && packet_error))
        else $error("valid sample flagged as error");
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
`endif

endmodule : pbf_back
`default_nettype wire

### rtl/pcm_bytes_to_float_samples_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_bytes_to_float_samples_unit
// PCM packet bytes to binary32 samples with channel and frame marks.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid / in_stall    | data_byte, packet_end
//  out     | out_valid / out_stall  | sample_valid .. packet_error
//  cfg     | cfg_we                 | cfg_index, cfg_data
//
// One byte per clock while in_stall is low. A result is presented once the
// byte completing it has passed the queue, convert stage and output register.
// The two-entry queue absorbs output stalls; in_stall rises when it is full.
// Reset clears position, channel and valid flags and sets the config registers to their defaults.
// ----------------------------------------------------------------------------
module pcm_bytes_to_float_samples_unit
    import pbf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        packet_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             sample_valid,
    output logic [31:0]      sample_value,
    output logic [2:0]       channel_index,
    output logic             frame_end,
    output logic             packet_error
);

    pbf_item_t f_item, q_item;
    logic      f_valid, q_full, q_ne, q_pop, in_fire;

    assign in_stall = q_full;
    assign in_fire  = in_valid && !in_stall;

    pbf_front u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_fire, .data_byte, .packet_end,
        .item(f_item), .item_valid(f_valid)
    );

    pbf_fifo u_fifo (
        .clk, .rst_n,
        .wr_en(f_valid && !cfg_we), .wr_item(f_item), .full(q_full),
        .rd_en(q_pop), .rd_item(q_item), .not_empty(q_ne)
    );

    pbf_back u_back (
        .clk, .rst_n, .q_valid(q_ne), .q_item, .q_pop,
        .out_valid, .out_stall,
        .sample_valid, .sample_value, .channel_index, .frame_end, .packet_error
    );

`ifndef SYNTHESIS
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_full) else $error("stall without full queue");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
    a_fire: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !q_full) else $error("byte taken into full queue");
`endif

endmodule : pcm_bytes_to_float_samples_unit
`default_nettype wire
